FILE: hdl/lbs_pkg.sv
package lbs_pkg;

    localparam int MAX_BONES_DEF      = 256;
    localparam int MAX_INFLUENCES_DEF = 4;
    localparam int WORDS_PER_BONE     = 12;
    localparam int ADDR_W             = 12;
    localparam int WORD_W             = 32;
    localparam int CFG_IDX_W          = 1;
    localparam int ACC_W              = 64;

    localparam logic [CFG_IDX_W-1:0] CFG_BONES_PER_VERTEX = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_BLEND_NORMALS    = 1'b1;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_SKIN = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_MUL,
        ST_SUM,
        ST_WEIGHT,
        ST_OUT
    } state_t;

    function automatic logic signed [WORD_W-1:0] sat32(input logic signed [ACC_W-1:0] v);
        logic signed [ACC_W-1:0] hi;
        logic signed [ACC_W-1:0] lo;
        hi = ACC_W'(64'sh7FFF_FFFF);
        lo = -ACC_W'(64'sh8000_0000);
        if (v > hi)
            sat32 = 32'sh7FFF_FFFF;
        else if (v < lo)
            sat32 = 32'sh8000_0000;
        else
            sat32 = v[WORD_W-1:0];
    endfunction

endpackage

FILE: hdl/lbs_palette.sv
module lbs_palette #(
    parameter int DEPTH = 3072
) (
    input  logic                                clk,
    input  logic                                we,
    input  logic [lbs_pkg::ADDR_W-1:0]          waddr,
    input  logic [lbs_pkg::WORD_W-1:0]          wdata,
    input  logic [lbs_pkg::ADDR_W-1:0]          raddr,
    output logic [lbs_pkg::WORD_W-1:0]          rdata
);
    import lbs_pkg::*;

    logic [WORD_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: hdl/linear_blend_vertex_skinning_top.sv
// channel | direction | handshake            | payload
// in      | input     | valid / ready        | op, palette_*, pos_*, normal_*, bone_*, last_vertex
// out     | output    | out_valid / out_ready | out_pos_*, out_normal_*, out_last
// cfg     | input     | cfg_we               | cfg_index, cfg_data
// A load beat leaves the block idle and ready. A vertex walks each bone slot used and skips
// zero-weight slots after the first: each of 3 components, point then normal, reads 4 palette
// words, each through a read, multiply and sum state, then passes through a weighting state.
// Reset clears control and configuration only; the palette is undefined until loaded.
// The result register holds while out_ready is low; a finished vertex waits for it.
module linear_blend_vertex_skinning_top #(
    parameter int MAX_BONES      = lbs_pkg::MAX_BONES_DEF,
    parameter int MAX_INFLUENCES = lbs_pkg::MAX_INFLUENCES_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [lbs_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [2:0]                         cfg_data,
    input  logic                               valid,
    output logic                               ready,
    input  logic                               op,
    input  logic [11:0]                        palette_address,
    input  logic signed [31:0]                 palette_value,
    input  logic signed [31:0]                 pos_x,
    input  logic signed [31:0]                 pos_y,
    input  logic signed [31:0]                 pos_z,
    input  logic signed [31:0]                 normal_x,
    input  logic signed [31:0]                 normal_y,
    input  logic signed [31:0]                 normal_z,
    input  logic [31:0]                        bone_indices,
    input  logic [31:0]                        bone_weights,
    input  logic                               last_vertex,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic signed [31:0]                 out_pos_x,
    output logic signed [31:0]                 out_pos_y,
    output logic signed [31:0]                 out_pos_z,
    output logic signed [31:0]                 out_normal_x,
    output logic signed [31:0]                 out_normal_y,
    output logic signed [31:0]                 out_normal_z,
    output logic                               out_last
);
    import lbs_pkg::*;

    localparam int DEPTH  = MAX_BONES * WORDS_PER_BONE;
    localparam int SLOT_W = (MAX_INFLUENCES > 2) ? $clog2(MAX_INFLUENCES) : 1;
    localparam int CNT_W  = $clog2(MAX_INFLUENCES + 1);

    // config
    logic [2:0] bpv_reg;
    logic       blend_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bpv_reg   <= 3'd4;
            blend_reg <= 1'b1;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_BONES_PER_VERTEX: bpv_reg   <= cfg_data;
                CFG_BLEND_NORMALS:    blend_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // state
    state_t state_reg, state_next;
    logic [SLOT_W-1:0] slot_reg;
    logic [3:0]        elem_reg;   // palette word being multiplied, 0..11
    logic              pn_reg;     // 0 point, 1 normal
    logic [1:0]        comp_reg;   // output component
    logic [CNT_W-1:0]  count_reg;

    logic signed [31:0] p_reg [3];
    logic signed [31:0] n_reg [3];
    logic [31:0] idx_reg, wt_reg;
    logic        last_reg;
    logic signed [ACC_W-1:0] accp_reg [3];
    logic signed [ACC_W-1:0] accn_reg [3];
    logic signed [ACC_W-1:0] vec_reg;
    logic signed [63:0] prod_reg;

    logic in_acc, out_acc;
    assign in_acc  = valid && ready;
    assign out_acc = out_valid && out_ready;

    // palette
    logic [7:0]  bone;
    logic        bone_ok;
    logic [ADDR_W-1:0] raddr;
    logic [WORD_W-1:0] rdata;
    logic signed [31:0] mword;
    logic        pal_we;

    assign bone    = idx_reg[8*slot_reg +: 8];
    assign bone_ok = 32'(bone) < 32'(MAX_BONES);
    assign raddr   = ADDR_W'(32'(bone) * WORDS_PER_BONE + 32'(elem_reg));
    assign pal_we  = in_acc && op == OP_LOAD && 32'(palette_address) < 32'(DEPTH);

    lbs_palette #(.DEPTH(DEPTH)) u_palette (
        .clk   (clk),
        .we    (pal_we),
        .waddr (palette_address),
        .wdata (palette_value),
        .raddr (raddr),
        .rdata (rdata)
    );

    logic bone_ok_reg;
    assign mword = bone_ok_reg ? $signed(rdata) : 32'sd0;

    logic [7:0] w;
    assign w = wt_reg[8*slot_reg +: 8];

    // sequencer: each slot walks components, point then normal, then three matrix terms and the pos word
    // elem for term t of component c is 3*t + c; pos word is 9 + c
    logic [1:0] term_reg;
    logic signed [31:0] src;
    always_comb
    begin
        if (pn_reg)
            src = n_reg[term_reg];
        else
            src = p_reg[term_reg];
    end

    logic last_slot;
    assign last_slot = (32'(slot_reg) + 1 >= 32'(count_reg));

    logic signed [ACC_W-1:0] scaled;
    assign scaled = (vec_reg * $signed({1'b0, w})) >>> 7;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:   if (in_acc && op == OP_SKIN) state_next = ST_READ;
            ST_READ:
            begin
                if (32'(slot_reg) != 0 && w == 8'd0)
                    state_next = last_slot ? ST_OUT : ST_READ;
                else
                    state_next = ST_MUL;
            end
            ST_MUL:    state_next = ST_SUM;
            ST_SUM:    state_next = (term_reg == 2'd3) ? ST_WEIGHT : ST_READ;
            ST_WEIGHT: state_next = (pn_reg && comp_reg == 2'd2 && last_slot) ? ST_OUT
                                                                              : ST_READ;
            ST_OUT:    if (out_acc || !out_valid) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            out_valid <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_OUT && (!out_valid || out_acc))
                out_valid <= 1'b1;
            else if (out_acc)
                out_valid <= 1'b0;
        end
    end

    assign ready = (state_reg == ST_IDLE);

    logic [2:0] cnt;
    always_comb
    begin
        cnt = bpv_reg;
        if (bpv_reg < 3'd2)
            cnt = 3'd2;
        if (32'(bpv_reg) > MAX_INFLUENCES)
            cnt = 3'(MAX_INFLUENCES);
    end

    always_ff @(posedge clk)
    begin
        bone_ok_reg <= bone_ok;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_acc && op == OP_SKIN)
                begin
                    p_reg[0] <= pos_x;    p_reg[1] <= pos_y;    p_reg[2] <= pos_z;
                    n_reg[0] <= normal_x; n_reg[1] <= normal_y; n_reg[2] <= normal_z;
                    idx_reg   <= bone_indices;
                    wt_reg    <= bone_weights;
                    last_reg  <= last_vertex;
                    count_reg <= CNT_W'(cnt);
                    slot_reg  <= '0;
                    comp_reg  <= 2'd0;
                    pn_reg    <= 1'b0;
                    term_reg  <= 2'd0;
                    elem_reg  <= 4'd0;
                    vec_reg   <= '0;
                    for (int c = 0; c < 3; c++)
                    begin
                        accp_reg[c] <= '0;
                        accn_reg[c] <= '0;
                    end
                end
            end
            ST_READ:
            begin
                if (32'(slot_reg) != 0 && w == 8'd0)
                begin
                    slot_reg <= SLOT_W'(32'(slot_reg) + 1);
                    elem_reg <= 4'd0;
                end
            end
            ST_MUL:
            begin
                if (term_reg == 2'd3)
                    prod_reg <= pn_reg ? 64'sd0 : (64'(mword) <<< 16);
                else
                    prod_reg <= src * mword;
            end
            ST_SUM:
            begin
                vec_reg  <= vec_reg + (prod_reg >>> 16);
                term_reg <= term_reg + 2'd1;
                if (term_reg == 2'd2)
                    elem_reg <= 4'(9 + 32'(comp_reg));
                else
                    elem_reg <= 4'(3 * (32'(term_reg) + 1) + 32'(comp_reg));
            end
            ST_WEIGHT:
            begin
                if (pn_reg)
                    accn_reg[comp_reg] <= accn_reg[comp_reg] + scaled;
                else
                    accp_reg[comp_reg] <= accp_reg[comp_reg] + scaled;
                vec_reg  <= '0;
                term_reg <= 2'd0;
                if (!pn_reg)
                begin
                    pn_reg   <= 1'b1;
                    elem_reg <= 4'(comp_reg);
                end
                else
                begin
                    pn_reg <= 1'b0;
                    if (comp_reg == 2'd2)
                    begin
                        comp_reg <= 2'd0;
                        elem_reg <= 4'd0;
                        if (!last_slot)
                            slot_reg <= SLOT_W'(32'(slot_reg) + 1);
                    end
                    else
                    begin
                        comp_reg <= comp_reg + 2'd1;
                        elem_reg <= 4'(32'(comp_reg) + 1);
                    end
                end
            end
            ST_OUT:
            begin
                if (!out_valid || out_acc)
                begin
                    out_pos_x    <= sat32(accp_reg[0]);
                    out_pos_y    <= sat32(accp_reg[1]);
                    out_pos_z    <= sat32(accp_reg[2]);
                    out_normal_x <= blend_reg ? sat32(accn_reg[0]) : 32'sd0;
                    out_normal_y <= blend_reg ? sat32(accn_reg[1]) : 32'sd0;
                    out_normal_z <= blend_reg ? sat32(accn_reg[2]) : 32'sd0;
                    out_last     <= last_reg;
                end
            end
            default: ;
        endcase
    end

`ifndef SYNTHESIS
    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        ready |-> state_reg == ST_IDLE)
        else $error("ready outside idle");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_pos_x))
        else $error("result dropped");
    a_no_load_busy: assert property (@(posedge clk) disable iff (!rst_n)
        pal_we |-> state_reg == ST_IDLE)
        else $error("palette write while busy");
`endif

endmodule
